FILE: rtl/core/edu_pkg.sv
// ----------------------------------------------------------------------------
// edu_pkg: constants and helpers for the equirectangular distance unit
// Fixed-point constants and the elaboration-time cosine table generator.
// ----------------------------------------------------------------------------
package edu_pkg;

    localparam int COS_TABLE_ENTRIES_DEF = 1024;

    // 90 degrees in 1e-7 degree
    localparam longint unsigned LAT_FULL        = 64'd900000000;
    localparam longint unsigned HALF_PI_Q30     = 64'd1686629713;
    localparam logic [16:0]     SCALE_MIN_Q16   = 17'd655;
    localparam longint unsigned MM_PER_UNIT_Q24 = 64'd186762031;
    // floor(2^48 / LAT_FULL), reciprocal for the divides by 90 degrees
    localparam longint unsigned LAT_RECIP_Q48   = (64'd1 << 48) / LAT_FULL;

    // shift-subtract quotient, used only while building the table
    function automatic longint unsigned udiv_u64(longint unsigned num,
                                                 longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Q16 cosine of a Q30 angle in radians; truncated Taylor terms, rounded half up.
    function automatic logic [16:0] cos_q16(longint unsigned x);
        longint unsigned x2;
        longint unsigned mag;
        longint          sum;
        logic            neg;
        x2  = (x * x) >> 30;
        mag = 64'd1 << 30;
        sum = longint'(64'd1 << 30);
        neg = 1'b1;
        for (int k = 0; k < 40; k++) begin
            mag = udiv_u64((mag * x2) >> 30, longint'((2 * k + 1) * (2 * k + 2)));
            sum = neg ? sum - longint'(mag) : sum + longint'(mag);
            neg = !neg;
        end
        if (sum < 0)
            sum = 0;
        sum = (sum + 64'sd8192) >>> 14;
        if (sum > 65536)
            sum = 65536;
        return 17'(sum);
    endfunction

endpackage

FILE: rtl/core/equirectangular_distance_unit.sv
// ----------------------------------------------------------------------------
// equirectangular_distance_unit: ground distance between two positions
// Fully pipelined equirectangular approximation, one request per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one position pair per request (lat/lon in signed
//   1e-7 degree); the m_ channel returns the distance in millimetres.
//   Every stage holds a valid bit; the whole pipeline advances whenever the
//   output register is empty or being taken, so a new request is accepted
//   every cycle while the receiver keeps up.
//   Depth: 47 register stages, from stage 0 to the output register that
//   drives m_. The depth comes from the table index and interpolation
//   divides by 90 degrees (three stages each: reciprocal-multiply estimate,
//   remainder, one compare-and-subtract) and the 32-stage integer square
//   root; it does not depend on COS_TABLE_ENTRIES.
//   Throughput: one result per cycle.
//   When m_tready is low with a result waiting, all stages hold and s_tready
//   drops; nothing is lost or repeated.
//   Reset (aresetn low, synchronous) clears all valid bits; the cosine table
//   is constant logic and needs no fill.
// ----------------------------------------------------------------------------
module equirectangular_distance_unit #(
    parameter int COS_TABLE_ENTRIES = edu_pkg::COS_TABLE_ENTRIES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_lat[30:0], start_lon[62:31], end_lat[93:63], end_lon[125:94], pad
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // distance_mm[35:0], pad
    output logic [39:0]  m_tdata
);
    import edu_pkg::*;

    localparam int N      = COS_TABLE_ENTRIES;
    localparam int IDX_W  = $clog2(N + 1);
    localparam int PW     = $clog2(64'(LAT_FULL) * 64'(N) + 64'd1);
    localparam int P2W    = 47;
    localparam int Q2W    = 17;
    localparam int RT_W   = 32;
    localparam int RCW    = $clog2(LAT_RECIP_Q48 + 64'd1);
    localparam int Q1W    = PW - 16 + RCW;
    localparam int Q2PW   = P2W - 16 + RCW;

    localparam int S_MUL  = 1;
    localparam int S_Q1   = 2;
    localparam int S_R1   = 3;
    localparam int S_C1   = 4;
    localparam int S_TAB  = 5;
    localparam int S_PRD  = 6;
    localparam int S_Q2   = 7;
    localparam int S_R2   = 8;
    localparam int S_C2   = 9;
    localparam int S_SCL  = 10;
    localparam int S_LNG  = S_SCL + 1;
    localparam int S_SQR  = S_LNG + 1;
    localparam int S_SUM  = S_SQR + 1;
    localparam int S_RT   = S_SUM + 1;
    localparam int S_OUT  = S_RT + RT_W;
    localparam int NST    = S_OUT + 1;

    typedef struct packed {
        logic [30:0]      alat;
        logic [31:0]      alon;
        logic [29:0]      lat_abs;
        logic [PW-1:0]    num;
        logic [IDX_W-1:0] idx;
        logic             at_end;
        logic [16:0]      hi;
        logic [16:0]      lo;
        logic [P2W-1:0]   num2;
        logic [Q2W-1:0]   q2;
        logic [16:0]      scale;
        logic [31:0]      blng;
        logic [61:0]      a2;
        logic [63:0]      b2;
        logic [63:0]      sq;
        logic [RT_W-1:0]  root;
        logic [35:0]      dist_mm;
    } item_t;

    item_t st_reg  [NST];
    item_t st_next [NST];
    logic  vld_reg [NST];
    logic  en;

    logic [16:0] cos_rom [0:N];

    for (genvar gi = 0; gi <= N; gi++) begin : g_rom
        localparam longint unsigned XV = (longint'(gi) * HALF_PI_Q30) / N;
        localparam logic [16:0]     CV = cos_q16(XV);
        assign cos_rom[gi] = CV;
    end

    assign en       = !vld_reg[NST-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = {4'b0, st_reg[NST-1].dist_mm};

    // stage 0: differences and magnitudes
    always_comb begin
        logic signed [30:0] slat, elat;
        logic signed [31:0] slon, elon;
        logic signed [31:0] dlat;
        logic signed [32:0] dlon;
        logic [30:0]        alat_s;
        slat = s_tdata[30:0];
        slon = s_tdata[62:31];
        elat = s_tdata[93:63];
        elon = s_tdata[125:94];
        dlat = 32'(elat) - 32'(slat);
        dlon = 33'(elon) - 33'(slon);
        st_next[0]      = '0;
        st_next[0].alat = dlat[31] ? 31'(-dlat) : dlat[30:0];
        st_next[0].alon = dlon[32] ? 32'(-dlon) : dlon[31:0];
        alat_s = slat[30] ? 31'(-slat) : 31'(slat);
        st_next[0].lat_abs = (64'(alat_s) > LAT_FULL) ? 30'(LAT_FULL) : alat_s[29:0];
    end

    always_comb begin
        st_next[S_MUL]     = st_reg[S_MUL-1];
        st_next[S_MUL].num = PW'(st_reg[S_MUL-1].lat_abs) * PW'(N);
        st_next[S_MUL].idx = '0;
    end

    // table index estimate by reciprocal multiply; low by at most one
    always_comb begin
        logic [Q1W-1:0] pr;
        st_next[S_Q1] = st_reg[S_Q1-1];
        pr = Q1W'(st_reg[S_Q1-1].num[PW-1:16]) * Q1W'(LAT_RECIP_Q48);
        st_next[S_Q1].idx = IDX_W'(pr >> 32);
    end

    always_comb begin
        st_next[S_R1]     = st_reg[S_R1-1];
        st_next[S_R1].num = st_reg[S_R1-1].num -
                            PW'(st_reg[S_R1-1].idx) * PW'(LAT_FULL);
    end

    always_comb begin
        st_next[S_C1] = st_reg[S_C1-1];
        if (st_reg[S_C1-1].num >= PW'(LAT_FULL)) begin
            st_next[S_C1].num = st_reg[S_C1-1].num - PW'(LAT_FULL);
            st_next[S_C1].idx = st_reg[S_C1-1].idx + IDX_W'(1);
        end
    end

    always_comb begin
        logic [IDX_W-1:0] ih, il;
        logic             last;
        st_next[S_TAB] = st_reg[S_TAB-1];
        last = st_reg[S_TAB-1].idx >= IDX_W'(N);
        ih   = last ? IDX_W'(N) : st_reg[S_TAB-1].idx;
        il   = last ? IDX_W'(N) : st_reg[S_TAB-1].idx + IDX_W'(1);
        st_next[S_TAB].at_end = last;
        st_next[S_TAB].hi     = cos_rom[ih];
        st_next[S_TAB].lo     = cos_rom[il];
    end

    always_comb begin
        logic [16:0] d;
        st_next[S_PRD] = st_reg[S_PRD-1];
        d = (st_reg[S_PRD-1].hi >= st_reg[S_PRD-1].lo) ?
            st_reg[S_PRD-1].hi - st_reg[S_PRD-1].lo : 17'd0;
        st_next[S_PRD].num2 = P2W'(d) * P2W'(st_reg[S_PRD-1].num[29:0]);
        st_next[S_PRD].q2   = '0;
    end

    // interpolation step estimate, same reciprocal; low by at most one
    always_comb begin
        logic [Q2PW-1:0] pr;
        st_next[S_Q2] = st_reg[S_Q2-1];
        pr = Q2PW'(st_reg[S_Q2-1].num2[P2W-1:16]) * Q2PW'(LAT_RECIP_Q48);
        st_next[S_Q2].q2 = Q2W'(pr >> 32);
    end

    always_comb begin
        st_next[S_R2]      = st_reg[S_R2-1];
        st_next[S_R2].num2 = st_reg[S_R2-1].num2 -
                             P2W'(st_reg[S_R2-1].q2) * P2W'(LAT_FULL);
    end

    always_comb begin
        st_next[S_C2] = st_reg[S_C2-1];
        if (st_reg[S_C2-1].num2 >= P2W'(LAT_FULL)) begin
            st_next[S_C2].num2 = st_reg[S_C2-1].num2 - P2W'(LAT_FULL);
            st_next[S_C2].q2   = st_reg[S_C2-1].q2 + Q2W'(1);
        end
    end

    always_comb begin
        logic [16:0] c;
        st_next[S_SCL] = st_reg[S_SCL-1];
        c = st_reg[S_SCL-1].at_end ? st_reg[S_SCL-1].hi
                                   : st_reg[S_SCL-1].hi - st_reg[S_SCL-1].q2;
        st_next[S_SCL].scale = (c < SCALE_MIN_Q16) ? SCALE_MIN_Q16 : c;
    end

    always_comb begin
        logic [48:0] pr;
        st_next[S_LNG] = st_reg[S_LNG-1];
        pr = 49'(st_reg[S_LNG-1].alon) * 49'(st_reg[S_LNG-1].scale);
        st_next[S_LNG].blng = pr[47:16];
    end

    always_comb begin
        st_next[S_SQR]    = st_reg[S_SQR-1];
        st_next[S_SQR].a2 = 62'(st_reg[S_SQR-1].alat) * 62'(st_reg[S_SQR-1].alat);
        st_next[S_SQR].b2 = 64'(st_reg[S_SQR-1].blng) * 64'(st_reg[S_SQR-1].blng);
    end

    always_comb begin
        logic [64:0] s65;
        st_next[S_SUM] = st_reg[S_SUM-1];
        s65 = 65'(st_reg[S_SUM-1].a2) + 65'(st_reg[S_SUM-1].b2);
        st_next[S_SUM].sq   = s65[64] ? '1 : s65[63:0];
        st_next[S_SUM].root = '0;
    end

    // digit-by-digit square root, one root bit per stage
    for (genvar g = 0; g < RT_W; g++) begin : g_sqrt
        localparam int J = RT_W - 1 - g;
        item_t       nxt;
        logic [65:0] trial;
        always_comb begin
            nxt   = st_reg[S_RT+g-1];
            trial = 66'({nxt.root, 2'b01}) << (2 * J);
            if (66'(nxt.sq) >= trial) begin
                nxt.sq   = nxt.sq - trial[63:0];
                nxt.root = {nxt.root[RT_W-2:0], 1'b1};
            end else begin
                nxt.root = {nxt.root[RT_W-2:0], 1'b0};
            end
        end
        assign st_next[S_RT+g] = nxt;
    end

    always_comb begin
        logic [63:0] mm;
        st_next[S_OUT] = st_reg[S_OUT-1];
        mm = (64'(st_reg[S_OUT-1].root) * MM_PER_UNIT_Q24) >> 24;
        st_next[S_OUT].dist_mm = mm[35:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NST; s++)
                vld_reg[s] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int s = 1; s < NST; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < NST; s++)
                st_reg[s] <= st_next[s];
        end
    end

`ifndef NO_ASSERTIONS
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[S_TAB-1] |-> (st_reg[S_TAB-1].idx <= IDX_W'(N)) &&
                             (st_reg[S_TAB-1].num < PW'(LAT_FULL)))
        else $error("table index divide out of range");

    a_interp_le_hi: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[S_SCL-1] |-> st_reg[S_SCL-1].q2 <= st_reg[S_SCL-1].hi)
        else $error("interpolation step exceeds table value");

    a_scale_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[S_SCL] |-> (st_reg[S_SCL].scale >= SCALE_MIN_Q16) &&
                           (st_reg[S_SCL].scale <= 17'd65536))
        else $error("longitude scale out of range");

    a_sqrt_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[S_OUT-1] |-> 65'(st_reg[S_OUT-1].sq) <= {32'd0, st_reg[S_OUT-1].root, 1'b0})
        else $error("square root remainder too large");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg[0]) && !s_tready == !en)
        else $error("pipeline moved while stalled");
`endif

endmodule
